/* design/spct_pkg.sv */
// spct_pkg: shared types and codes for the servo pulse countdown timer.
// No dependencies; every other design file refers to it by scoped names.
package spct_pkg;

   localparam int unsigned COUNT_W = 24;

   // item kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_ANGLE = 2'd1;
   localparam logic [1:0] KIND_LOAD  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_TIMER_MODE = 2'd0;
   localparam logic [1:0] CSR_ON_ANGLE   = 2'd1;
   localparam logic [1:0] CSR_OFF_ANGLE  = 2'd2;

   // expiry actions
   localparam logic [1:0] MODE_SERVO_ON  = 2'd0;
   localparam logic [1:0] MODE_SERVO_OFF = 2'd1;
   localparam logic [1:0] MODE_SIGNAL    = 2'd2;
   localparam logic [1:0] MODE_NONE      = 2'd3;

   localparam logic [7:0] ON_ANGLE_RESET  = 8'd0;
   localparam logic [7:0] OFF_ANGLE_RESET = 8'd180;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] angle;
      logic [6:0] days;
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
      logic       waiting_flag;
   } req_type;

   typedef struct packed {
      logic [4:0] pwm_compare;
      logic       display_off;
      logic       wake;
      logic       timer_done;
      logic [6:0] left_days;
      logic [4:0] left_hours;
      logic [5:0] left_minutes;
      logic [5:0] left_seconds;
   } rsp_type;

   // staged command: the timer load is already scaled to countdown units
   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         angle;
      logic               waiting_flag;
      logic [COUNT_W-1:0] load;
   } cmd_type;

   // result of the state update, before the time split
   typedef struct packed {
      logic [4:0]         compare;
      logic               display_off;
      logic               wake;
      logic               timer_done;
      logic [COUNT_W-1:0] count;
   } tick_type;

   // configuration register write
   typedef struct packed {
      logic       write;
      logic [1:0] index;
      logic [7:0] wdata;
   } csr_type;

endpackage

/* design/servo_pulse_countdown_timer_core.sv */
// servo_pulse_countdown_timer_core: top level of the servo switch countdown timer.
// Depends on spct_pkg, spct_intake, spct_state and spct_split.
//
// Takes one word per cycle on req_ (tick, angle command or timer load) when req_stall
// is low, and gives exactly one result word per accepted word on rsp_, in order. The
// input register feeds the state update (pulse counter, countdown, servo compare),
// which is registered, and three further registered steps split the remaining time
// into days, hours, minutes and seconds. Sustained rate is one word per cycle;
// rsp_stall backs up through the stages and a stage with a bubble keeps accepting.
// The csr_ port is always ready; write it only while no words are in flight.
module servo_pulse_countdown_timer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  spct_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output spct_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

   logic               s0_valid;
   spct_pkg::cmd_type  s0_cmd;
   logic               s1_free;
   logic               s1_valid;
   spct_pkg::tick_type s1_tick;
   logic               s2_free;
   spct_pkg::csr_type  csr;

   assign csr_ready = 1'b1;

   always_comb begin
      csr.write = csr_valid && csr_ready;
      csr.index = csr_index;
      csr.wdata = csr_wdata;
   end

   spct_intake u_intake (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .s0_valid  (s0_valid),
      .s0_cmd    (s0_cmd),
      .s1_free   (s1_free)
   );

   spct_state u_state (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .s0_valid (s0_valid),
      .s0_cmd   (s0_cmd),
      .s1_free  (s1_free),
      .s1_valid (s1_valid),
      .s1_tick  (s1_tick),
      .s2_free  (s2_free)
   );

   spct_split u_split (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_tick   (s1_tick),
      .s2_free   (s2_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

/* design/spct_intake.sv */
// spct_intake: input register of the timer; scales a timer load to 1.5x seconds.
// Depends on spct_pkg.
module spct_intake (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  spct_pkg::req_type req_word,
   output logic              s0_valid,
   output spct_pkg::cmd_type s0_cmd,
   input  logic              s1_free
);

   localparam logic [24:0] DAY_SECONDS    = 25'd86400;
   localparam logic [24:0] HOUR_SECONDS   = 25'd3600;
   localparam logic [24:0] MINUTE_SECONDS = 25'd60;

   logic              s0_valid_ff;
   logic              s0_valid_in;
   spct_pkg::cmd_type s0_cmd_ff;
   spct_pkg::cmd_type s0_cmd_in;
   logic              free0;
   logic [24:0]       total;
   logic [24:0]       scaled;

   assign free0     = !s0_valid_ff || s1_free;
   assign req_stall = !free0;

   always_comb begin
      total = 25'(req_word.days) * DAY_SECONDS
            + 25'(req_word.hours) * HOUR_SECONDS
            + 25'(req_word.minutes) * MINUTE_SECONDS
            + 25'(req_word.seconds);
      scaled = total + (total >> 1);
      s0_cmd_in.kind         = req_word.kind;
      s0_cmd_in.angle        = req_word.angle;
      s0_cmd_in.waiting_flag = req_word.waiting_flag;
      s0_cmd_in.load         = scaled[spct_pkg::COUNT_W-1:0];
   end

   assign s0_valid_in = free0 ? req_valid : s0_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && free0) begin
         s0_cmd_ff <= s0_cmd_in;
      end
   end

   assign s0_valid = s0_valid_ff;
   assign s0_cmd   = s0_cmd_ff;

endmodule

/* design/spct_state.sv */
// spct_state: configuration registers, pulse counter, countdown and compare state.
// Depends on spct_pkg.
module spct_state (
   input  logic               clock,
   input  logic               reset,
   input  spct_pkg::csr_type  csr,
   input  logic               s0_valid,
   input  spct_pkg::cmd_type  s0_cmd,
   output logic               s1_free,
   output logic               s1_valid,
   output spct_pkg::tick_type s1_tick,
   input  logic               s2_free
);

   localparam logic [4:0] PULSE_CLEAR_AT = 5'd1;
   localparam logic [4:0] DISPLAY_OFF_AT = 5'd10;
   localparam logic [4:0] PULSE_LIMIT    = 5'd20;

   logic [1:0]                   mode_ff;
   logic [7:0]                   on_angle_ff;
   logic [7:0]                   off_angle_ff;
   logic [4:0]                   pulse_ff;
   logic [4:0]                   pulse_in;
   logic [spct_pkg::COUNT_W-1:0] count_ff;
   logic [spct_pkg::COUNT_W-1:0] count_in;
   logic [spct_pkg::COUNT_W-1:0] count_dec;
   logic [4:0]                   compare_ff;
   logic [4:0]                   compare_in;
   logic                         disp;
   logic                         wake;
   logic                         done;
   logic                         take;
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   spct_pkg::tick_type           s1_tick_ff;
   spct_pkg::tick_type           s1_tick_in;

   // floor(deg / 10) + 6, exact for 8-bit degrees
   function automatic logic [4:0] to_compare(input logic [7:0] deg);
      logic [15:0] p;
      p = 16'(deg) * 16'd205;
      return 5'(p[15:11] + 5'd6);
   endfunction

   // 4 = 1 mod 3, so base-4 digit sums keep the residue
   function automatic logic mod3_zero(input logic [spct_pkg::COUNT_W-1:0] v);
      logic [5:0] s1;
      logic [3:0] s2;
      logic [2:0] s3;
      s1 = 6'd0;
      for (int i = 0; i < spct_pkg::COUNT_W / 2; i++) begin
         s1 = s1 + 6'(v[2*i +: 2]);
      end
      s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]);
      s3 = 3'(s2[1:0]) + 3'(s2[3:2]);
      return (s3 == 3'd0) || (s3 == 3'd3);
   endfunction

   assign s1_free = !s1_valid_ff || s2_free;
   assign take    = s0_valid && s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= spct_pkg::MODE_NONE;
         on_angle_ff  <= spct_pkg::ON_ANGLE_RESET;
         off_angle_ff <= spct_pkg::OFF_ANGLE_RESET;
      end else if (csr.write) begin
         case (csr.index)
            spct_pkg::CSR_TIMER_MODE: mode_ff      <= csr.wdata[1:0];
            spct_pkg::CSR_ON_ANGLE:   on_angle_ff  <= csr.wdata;
            spct_pkg::CSR_OFF_ANGLE:  off_angle_ff <= csr.wdata;
            default: ;
         endcase
      end
   end

   assign count_dec = (count_ff != '0) ? count_ff - 1'b1 : count_ff;

   always_comb begin
      pulse_in   = pulse_ff;
      count_in   = count_ff;
      compare_in = compare_ff;
      disp       = 1'b0;
      wake       = 1'b0;
      done       = 1'b0;
      case (s0_cmd.kind)
         spct_pkg::KIND_ANGLE: begin
            compare_in = to_compare(s0_cmd.angle);
            pulse_in   = 5'd0;
         end
         spct_pkg::KIND_LOAD: begin
            count_in = s0_cmd.load;
         end
         spct_pkg::KIND_TICK: begin
            if (pulse_ff == PULSE_CLEAR_AT) begin
               compare_in = 5'd0;
            end
            disp = (pulse_ff == DISPLAY_OFF_AT);
            if (pulse_ff < PULSE_LIMIT) begin
               pulse_in = pulse_ff + 5'd1;
            end
            wake     = s0_cmd.waiting_flag && mod3_zero(count_ff);
            count_in = count_dec;
            if (count_dec == spct_pkg::COUNT_W'(1)) begin
               case (mode_ff)
                  spct_pkg::MODE_SERVO_ON: begin
                     compare_in = to_compare(on_angle_ff);
                     pulse_in   = 5'd0;
                  end
                  spct_pkg::MODE_SERVO_OFF: begin
                     compare_in = to_compare(off_angle_ff);
                     pulse_in   = 5'd0;
                  end
                  spct_pkg::MODE_SIGNAL: done = 1'b1;
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      s1_tick_in.compare     = compare_in;
      s1_tick_in.display_off = disp;
      s1_tick_in.wake        = wake;
      s1_tick_in.timer_done  = done;
      s1_tick_in.count       = count_in;
   end

   assign s1_valid_in = s1_free ? s0_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff    <= 5'd0;
         count_ff    <= '0;
         compare_ff  <= 5'd0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (take) begin
            pulse_ff   <= pulse_in;
            count_ff   <= count_in;
            compare_ff <= compare_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_tick_ff <= s1_tick_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_tick  = s1_tick_ff;

endmodule

/* design/spct_split.sv */
// spct_split: splits the remaining time into days, hours, minutes, seconds
// over two stages and the result register. Depends on spct_pkg.
module spct_split (
   input  logic               clock,
   input  logic               reset,
   input  logic               s1_valid,
   input  spct_pkg::tick_type s1_tick,
   output logic               s2_free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output spct_pkg::rsp_type  rsp_word
);

   localparam int unsigned PROD_W = 49;
   // exact reciprocals for 24-bit counts: c/129600, c/5400, c/90
   localparam logic [24:0] RECIP_DAY  = 25'd16967773;
   localparam logic [24:0] RECIP_HOUR = 25'd25451659;
   localparam logic [24:0] RECIP_MIN  = 25'd23860930;
   localparam int unsigned SHIFT_DAY  = 41;
   localparam int unsigned SHIFT_HOUR = 37;
   localparam int unsigned SHIFT_MIN  = 31;

   typedef struct packed {
      logic [4:0]                   compare;
      logic                         display_off;
      logic                         wake;
      logic                         timer_done;
      logic [spct_pkg::COUNT_W-1:0] count;
      logic [7:0]                   qd;
      logic [11:0]                  qh;
      logic [17:0]                  qm;
   } quot_type;

   typedef struct packed {
      logic [4:0] compare;
      logic       display_off;
      logic       wake;
      logic       timer_done;
      logic [6:0] days;
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [6:0] rem;
   } part_type;

   logic              s2_valid_ff;
   logic              s2_valid_in;
   quot_type          s2_ff;
   quot_type          s2_in;
   logic              s3_valid_ff;
   logic              s3_valid_in;
   part_type          s3_ff;
   part_type          s3_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   spct_pkg::rsp_type rsp_ff;
   spct_pkg::rsp_type rsp_in;
   logic              s3_free;
   logic              out_free;
   logic [PROD_W-1:0] prod_d;
   logic [PROD_W-1:0] prod_h;
   logic [PROD_W-1:0] prod_m;
   logic [11:0]       hours_full;
   logic [17:0]       minutes_full;
   logic [spct_pkg::COUNT_W-1:0] rem_full;
   logic [7:0]        twice_rem;
   logic [15:0]       prod_s;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s3_free  = !s3_valid_ff || out_free;
   assign s2_free  = !s2_valid_ff || s3_free;

   // quotient stage
   always_comb begin
      prod_d = PROD_W'(s1_tick.count) * PROD_W'(RECIP_DAY);
      prod_h = PROD_W'(s1_tick.count) * PROD_W'(RECIP_HOUR);
      prod_m = PROD_W'(s1_tick.count) * PROD_W'(RECIP_MIN);
      s2_in.compare     = s1_tick.compare;
      s2_in.display_off = s1_tick.display_off;
      s2_in.wake        = s1_tick.wake;
      s2_in.timer_done  = s1_tick.timer_done;
      s2_in.count       = s1_tick.count;
      s2_in.qd          = 8'(prod_d >> SHIFT_DAY);
      s2_in.qh          = 12'(prod_h >> SHIFT_HOUR);
      s2_in.qm          = 18'(prod_m >> SHIFT_MIN);
   end

   // remainder stage
   always_comb begin
      hours_full   = s2_ff.qh - 12'(s2_ff.qd) * 12'd24;
      minutes_full = s2_ff.qm - 18'(s2_ff.qh) * 18'd60;
      rem_full     = s2_ff.count - spct_pkg::COUNT_W'(s2_ff.qm) * spct_pkg::COUNT_W'(90);
      s3_in.compare     = s2_ff.compare;
      s3_in.display_off = s2_ff.display_off;
      s3_in.wake        = s2_ff.wake;
      s3_in.timer_done  = s2_ff.timer_done;
      s3_in.days        = (s2_ff.qd > 8'd127) ? 7'd127 : s2_ff.qd[6:0];
      s3_in.hours       = hours_full[4:0];
      s3_in.minutes     = minutes_full[5:0];
      s3_in.rem         = rem_full[6:0];
   end

   // seconds = floor(2 * rem / 3)
   always_comb begin
      twice_rem = {s3_ff.rem, 1'b0};
      prod_s    = 16'(twice_rem) * 16'd171;
      rsp_in.pwm_compare  = s3_ff.compare;
      rsp_in.display_off  = s3_ff.display_off;
      rsp_in.wake         = s3_ff.wake;
      rsp_in.timer_done   = s3_ff.timer_done;
      rsp_in.left_days    = s3_ff.days;
      rsp_in.left_hours   = s3_ff.hours;
      rsp_in.left_minutes = s3_ff.minutes;
      rsp_in.left_seconds = prod_s[14:9];
   end

   assign s2_valid_in  = s2_free ? s1_valid : s2_valid_ff;
   assign s3_valid_in  = s3_free ? s2_valid_ff : s3_valid_ff;
   assign rsp_valid_in = out_free ? s3_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid && s2_free) begin
         s2_ff <= s2_in;
      end
      if (s2_valid_ff && s3_free) begin
         s3_ff <= s3_in;
      end
      if (s3_valid_ff && out_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

/* design/spct_checker.sv */
// spct_checker: port-level checks for servo_pulse_countdown_timer_core, bound below.
// Depends on spct_pkg and the top level's ports.
module spct_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input spct_pkg::rsp_type rsp_word
);

   // stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   // with the result register empty nothing inside can block the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output empty");

   // expiry leaves less than one second on the clock
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.timer_done |->
         rsp_word.left_days == 7'd0 && rsp_word.left_hours == 5'd0 &&
         rsp_word.left_minutes == 6'd0 && rsp_word.left_seconds == 6'd0)
      else $error("timer done with time remaining");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.left_hours < 5'd24 && rsp_word.left_minutes < 6'd60 &&
         rsp_word.left_seconds < 6'd60)
      else $error("time split out of range");

endmodule

bind servo_pulse_countdown_timer_core spct_checker u_checker (.*);

/* tb/tb_top.sv */
// tb_top: self-checking testbench for servo_pulse_countdown_timer_core.
// Runs directed and random words against a built-in timer predictor with idling and stalls.
// Depends on spct_pkg and the design files under design/.
module tb_top;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED  = 2'd3;
   localparam int unsigned DAY_SECS    = 86400;
   localparam int unsigned HOUR_SECS   = 3600;
   localparam int unsigned MINUTE_SECS = 60;
   localparam int unsigned CLEAR_TICK  = 1;
   localparam int unsigned DISPLAY_TICK = 10;
   localparam int unsigned TICK_LIMIT  = 20;
   localparam int unsigned WAKE_PERIOD = 3;
   localparam int unsigned DAYS_MAX    = 127;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int HOLD_AT     = 60;
   localparam int REQ_W       = $bits(spct_pkg::req_type);

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   spct_pkg::req_type req_word = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   spct_pkg::rsp_type rsp_word;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = '0;
   logic [7:0]        csr_wdata = '0;

   // predictor state and registers
   logic [4:0]  servo_ticks = '0;
   logic [4:0]  servo_compare = '0;
   int unsigned count_left = 0;
   logic [1:0]  cfg_mode = spct_pkg::MODE_NONE;
   logic [7:0]  cfg_on_angle = spct_pkg::ON_ANGLE_RESET;
   logic [7:0]  cfg_off_angle = spct_pkg::OFF_ANGLE_RESET;

   spct_pkg::req_type item_queue[$];
   spct_pkg::rsp_type expected_words[$];
   logic    req_taken = 1'b0;
   int      errors = 0;
   int      rsp_count = 0;
   int      csr_writes = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_cycles = 0;
   logic    hold_done = 1'b0;
   int      quiet_cycles = 0;

   servo_pulse_countdown_timer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_error(string msg);
      $display("error at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want) begin
         report_error($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   function automatic void aim_servo(logic [7:0] deg);
      servo_compare = 5'(deg / 8'd10 + 8'd6);
      servo_ticks = '0;
   endfunction

   function automatic spct_pkg::rsp_type advance_timer(spct_pkg::req_type w);
      spct_pkg::rsp_type r;
      int unsigned       total;
      int unsigned       secs;
      int unsigned       d;
      r = '0;
      case (w.kind)
         spct_pkg::KIND_ANGLE: aim_servo(w.angle);
         spct_pkg::KIND_LOAD: begin
            total = DAY_SECS * w.days + HOUR_SECS * w.hours + MINUTE_SECS * w.minutes
                  + w.seconds;
            count_left = (total * 3) / 2;
         end
         spct_pkg::KIND_TICK: begin
            if (servo_ticks == CLEAR_TICK) servo_compare = '0;
            if (servo_ticks == DISPLAY_TICK) r.display_off = 1'b1;
            if (servo_ticks < TICK_LIMIT) servo_ticks++;
            r.wake = w.waiting_flag && (count_left % WAKE_PERIOD == 0);
            if (count_left > 0) count_left--;
            if (count_left == 1) begin
               case (cfg_mode)
                  spct_pkg::MODE_SERVO_ON:  aim_servo(cfg_on_angle);
                  spct_pkg::MODE_SERVO_OFF: aim_servo(cfg_off_angle);
                  spct_pkg::MODE_SIGNAL:    r.timer_done = 1'b1;
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      secs = count_left * 2 / 3;
      d = secs / DAY_SECS;
      secs = secs % DAY_SECS;
      r.pwm_compare = servo_compare;
      r.left_days = (d > DAYS_MAX) ? 7'(DAYS_MAX) : 7'(d);
      r.left_hours = 5'(secs / HOUR_SECS);
      r.left_minutes = 6'((secs % HOUR_SECS) / MINUTE_SECS);
      r.left_seconds = 6'(secs % MINUTE_SECS);
      return r;
   endfunction

   function automatic spct_pkg::req_type make_word(logic [1:0] kind, logic [7:0] angle,
                                                   logic [6:0] d, logic [4:0] h,
                                                   logic [5:0] m, logic [5:0] s,
                                                   logic flag);
      spct_pkg::req_type w;
      w.kind = kind;
      w.angle = angle;
      w.days = d;
      w.hours = h;
      w.minutes = m;
      w.seconds = s;
      w.waiting_flag = flag;
      return w;
   endfunction

   // tick with random payload, now and then an angle command
   function automatic spct_pkg::req_type run_word();
      logic [7:0] deg;
      deg = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(180));
      if ($urandom_range(11) == 0) return make_word(spct_pkg::KIND_ANGLE, deg, 7'($urandom),
                                                    5'($urandom), 6'($urandom),
                                                    6'($urandom), 1'($urandom));
      return make_word(spct_pkg::KIND_TICK, 8'($urandom), 7'($urandom), 5'($urandom),
                       6'($urandom), 6'($urandom), 1'($urandom));
   endfunction

   task automatic queue_random_items(int unsigned n);
      int unsigned added;
      int unsigned ticks;
      int unsigned mins;
      int unsigned secs;
      logic [63:0] raw;
      added = 0;
      while (added < n) begin
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               mins = ($urandom_range(7) == 0) ? 1 : 0;
               secs = $urandom_range(9);
               item_queue.push_back(make_word(spct_pkg::KIND_LOAD, 8'($urandom), 0, 0,
                                              6'(mins), 6'(secs), 1'($urandom)));
               ticks = (mins * MINUTE_SECS + secs) * 3 / 2 + $urandom_range(3);
               repeat (ticks) item_queue.push_back(run_word());
               added += ticks + 1;
            end
            4, 5, 6: begin
               item_queue.push_back(make_word(spct_pkg::KIND_ANGLE, 8'($urandom_range(180)),
                                              7'($urandom), 5'($urandom), 6'($urandom),
                                              6'($urandom), 1'($urandom)));
               ticks = $urandom_range(24, 5);
               repeat (ticks) item_queue.push_back(run_word());
               added += ticks + 1;
            end
            default: begin
               raw = {$urandom, $urandom};
               item_queue.push_back(raw[REQ_W-1:0]);
               added++;
            end
         endcase
      end
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      int seen;
      @(negedge clock);
      seen = csr_writes;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(negedge clock); while (csr_writes == seen);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (item_queue.size() != 0 || req_valid || expected_words.size() != 0);
   endtask

   // word driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (item_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_word <= item_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && rsp_count >= HOLD_AT) begin
         hold_cycles <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // predictor and result monitor
   always @(posedge clock) begin
      spct_pkg::rsp_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            csr_writes++;
            case (csr_index)
               spct_pkg::CSR_TIMER_MODE: cfg_mode = csr_wdata[1:0];
               spct_pkg::CSR_ON_ANGLE:   cfg_on_angle = csr_wdata;
               spct_pkg::CSR_OFF_ANGLE:  cfg_off_angle = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_words.push_back(advance_timer(req_word));
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_words.size() == 0) begin
               report_error("result word with nothing expected");
            end else begin
               want = expected_words.pop_front();
               check_field("pwm_compare", int'(rsp_word.pwm_compare),
                           int'(want.pwm_compare));
               check_field("display_off", int'(rsp_word.display_off),
                           int'(want.display_off));
               check_field("wake", int'(rsp_word.wake), int'(want.wake));
               check_field("timer_done", int'(rsp_word.timer_done), int'(want.timer_done));
               check_field("left_days", int'(rsp_word.left_days), int'(want.left_days));
               check_field("left_hours", int'(rsp_word.left_hours), int'(want.left_hours));
               check_field("left_minutes", int'(rsp_word.left_minutes),
                           int'(want.left_minutes));
               check_field("left_seconds", int'(rsp_word.left_seconds),
                           int'(want.left_seconds));
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [1:0] mode;
      logic [7:0] on_deg;
      logic [7:0] off_deg;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      send_idle_pct = 22;
      recv_idle_pct = 67;
      item_queue.push_back(make_word(spct_pkg::KIND_TICK, 0, 0, 0, 0, 0, 1'b1));
      item_queue.push_back(make_word(KIND_UNUSED, 8'hFF, 7'h7F, 5'h1F, 6'h3F, 6'h3F, 1'b1));
      item_queue.push_back(make_word(spct_pkg::KIND_ANGLE, 8'd0, 0, 0, 0, 0, 1'b0));
      item_queue.push_back(make_word(spct_pkg::KIND_ANGLE, 8'd255, 0, 0, 0, 0, 1'b0));
      item_queue.push_back(make_word(spct_pkg::KIND_ANGLE, 8'd180, 0, 0, 0, 0, 1'b0));
      item_queue.push_back(make_word(spct_pkg::KIND_LOAD, 0, 7'd127, 5'd31, 6'd63, 6'd63,
                                     1'b0));
      item_queue.push_back(make_word(spct_pkg::KIND_LOAD, 0, 7'd99, 5'd23, 6'd59, 6'd59,
                                     1'b0));
      item_queue.push_back(make_word(spct_pkg::KIND_TICK, 0, 0, 0, 0, 0, 1'b1));
      item_queue.push_back(make_word(spct_pkg::KIND_LOAD, 0, 0, 0, 0, 0, 1'b0));
      item_queue.push_back(make_word(spct_pkg::KIND_LOAD, 0, 0, 0, 0, 6'd2, 1'b0));
      item_queue.push_back(make_word(spct_pkg::KIND_TICK, 0, 0, 0, 0, 0, 1'b1));
      item_queue.push_back(make_word(spct_pkg::KIND_TICK, 0, 0, 0, 0, 0, 1'b0));
      item_queue.push_back(make_word(spct_pkg::KIND_TICK, 0, 0, 0, 0, 0, 1'b1));
      repeat (9) item_queue.push_back(make_word(spct_pkg::KIND_TICK, 0, 0, 0, 0, 0, 1'b1));

      for (int p = 0; p < 6; p++) begin
         wait_drained();
         case (p / 2)
            0: begin send_idle_pct = 22; recv_idle_pct = 67; end
            1: begin send_idle_pct = 67; recv_idle_pct = 22; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         case (p)
            0: begin
               mode = spct_pkg::MODE_SERVO_ON;  on_deg = 8'd0;   off_deg = 8'd180;
            end
            1: begin
               mode = spct_pkg::MODE_SERVO_OFF; on_deg = 8'd255; off_deg = 8'd0;
            end
            2: begin
               mode = spct_pkg::MODE_SIGNAL;    on_deg = 8'd180; off_deg = 8'd255;
            end
            3: begin
               mode = spct_pkg::MODE_NONE;      on_deg = 8'd90;  off_deg = 8'd45;
            end
            4: begin
               mode = 2'($urandom); on_deg = 8'($urandom); off_deg = 8'($urandom);
            end
            default: begin
               mode = spct_pkg::MODE_SERVO_ON;  on_deg = 8'd255; off_deg = 8'd255;
            end
         endcase
         write_reg(spct_pkg::CSR_TIMER_MODE, {6'd0, mode});
         write_reg(spct_pkg::CSR_ON_ANGLE, on_deg);
         write_reg(spct_pkg::CSR_OFF_ANGLE, off_deg);
         if (p == 3) write_reg(CSR_UNUSED, 8'hFF);
         queue_random_items(80);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (expected_words.size() != 0) begin
         report_error($sformatf("%0d result words never came", expected_words.size()));
      end
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* files.f */
design/spct_pkg.sv
design/spct_intake.sv
design/spct_state.sv
design/spct_split.sv
design/servo_pulse_countdown_timer_core.sv
design/spct_checker.sv
tb/tb_top.sv
